@@ sv/tea_pkg.sv @@
// tea_pkg: shared types, constants and the round mix function of the tea block cipher
// depends on nothing; imported by tea_round and tea_block_cipher
package tea_pkg;

    localparam int TeaRounds = 32;
    localparam logic [31:0] TeaDelta = 32'h9e3779b9;
    localparam int TeaShiftLeft = 4;
    localparam int TeaShiftRight = 5;

    localparam logic [31:0] TeaKeyReset0 = 32'h78563412;
    localparam logic [31:0] TeaKeyReset1 = 32'hf0debc9a;
    localparam logic [31:0] TeaKeyReset2 = 32'h44332211;
    localparam logic [31:0] TeaKeyReset3 = 32'h88776655;

    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    localparam int AddrWidth = 4;

    typedef enum logic [1:0] {
        RegKey0 = 2'd0,
        RegKey1 = 2'd1,
        RegKey2 = 2'd2,
        RegKey3 = 2'd3
    } tea_reg_t;

    typedef struct packed {
        logic        op;
        logic [31:0] half_a_in;
        logic [31:0] half_b_in;
        logic        last_in;
    } tea_in_t;

    typedef struct packed {
        logic [31:0] half_a_out;
        logic [31:0] half_b_out;
        logic        last_out;
    } tea_out_t;

    typedef struct packed {
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
    } tea_stage_t;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } tea_key_t;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] sum,
        input logic [31:0] kl,
        input logic [31:0] kr
    );
        tea_mix = ((x << TeaShiftLeft) + kl) ^ (x + sum) ^ ((x >> TeaShiftRight) + kr);
    endfunction

endpackage

@@ sv/tea_round.sv @@
// tea_round: one half-round of tea as a registered pipeline stage with valid/ready
// depends on tea_pkg (stage and key structs, tea_mix)
module tea_round
    import tea_pkg::*;
#(
    parameter int ROUNDS = TeaRounds,
    parameter int STAGE = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tea_key_t   key,
    input  logic       up_valid,
    output logic       up_ready,
    input  tea_stage_t up,
    output logic       dn_valid,
    input  logic       dn_ready,
    output tea_stage_t dn
);

    localparam int RoundIdx = STAGE / 2;
    localparam bit SecondHalf = (STAGE % 2) == 1;
    localparam logic [63:0] SumEncWide = 64'(TeaDelta) * 64'(RoundIdx + 1);
    localparam logic [63:0] SumDecWide = 64'(TeaDelta) * 64'(ROUNDS - RoundIdx);
    localparam logic [31:0] SumEnc = SumEncWide[31:0];
    localparam logic [31:0] SumDec = SumDecWide[31:0];

    logic       valid_reg;
    tea_stage_t data_reg;
    tea_stage_t data_next;

    logic        upd_a;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] kl;
    logic [31:0] kr;
    logic [31:0] sum;
    logic [31:0] mix;
    logic [31:0] res;

    // encrypt updates a first, decrypt undoes b first
    always_comb
    begin
        upd_a = (up.op == OpEncrypt) ^ SecondHalf;
        src   = upd_a ? up.b : up.a;
        dst   = upd_a ? up.a : up.b;
        kl    = upd_a ? key.k0 : key.k2;
        kr    = upd_a ? key.k1 : key.k3;
        sum   = (up.op == OpEncrypt) ? SumEnc : SumDec;
        mix   = tea_mix(src, sum, kl, kr);
        res   = (up.op == OpEncrypt) ? (dst + mix) : (dst - mix);
        data_next = up;
        if (upd_a)
        begin
            data_next.a = res;
        end
        else
        begin
            data_next.b = res;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=> valid_reg)
        else $error("accepted block did not land in stage register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled stage lost or changed its block");

    a_side_fields: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=> data_reg.op == $past(up.op) && data_reg.last == $past(up.last))
        else $error("op or last flag altered by round stage");

    a_one_half: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=>
            (data_reg.a == $past(up.a)) || (data_reg.b == $past(up.b)))
        else $error("half-round changed both words");

endmodule

@@ sv/tea_block_cipher.sv @@
// tea_block_cipher: tea ecb block cipher, one half-round per pipeline stage, apb key registers
// depends on tea_pkg and tea_round
//
//  channel  direction  signals                        payload
//  blk      in         blk_valid / blk_ready          tea_in_t  (op, half_a_in, half_b_in, last_in)
//  res      out        res_valid / res_ready          tea_out_t (half_a_out, half_b_out, last_out)
//  apb      in/out     psel penable pwrite paddr ...  key_word0..3 at bytes 0, 4, 8, 12
//
// one registered stage per half-round, each stage one mix term and one add or subtract;
// a new block is taken every cycle unless a stall at res has backed up to blk.
// reset loads the default key and empties the pipeline; no clearing pass.
// a stall at res holds full stages backed up to res; empty stages still fill, so bubbles close up.
module tea_block_cipher
    import tea_pkg::*;
#(
    parameter int ROUNDS = TeaRounds
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 blk_valid,
    output logic                 blk_ready,
    input  tea_in_t              blk,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tea_out_t             res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int Stages = 2 * ROUNDS;

    tea_key_t key_reg;
    tea_reg_t reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = tea_reg_t'(paddr[AddrWidth-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg.k0 <= TeaKeyReset0;
            key_reg.k1 <= TeaKeyReset1;
            key_reg.k2 <= TeaKeyReset2;
            key_reg.k3 <= TeaKeyReset3;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                RegKey0: key_reg.k0 <= pwdata;
                RegKey1: key_reg.k1 <= pwdata;
                RegKey2: key_reg.k2 <= pwdata;
                RegKey3: key_reg.k3 <= pwdata;
                default: key_reg.k0 <= key_reg.k0;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            RegKey0: prdata = key_reg.k0;
            RegKey1: prdata = key_reg.k1;
            RegKey2: prdata = key_reg.k2;
            RegKey3: prdata = key_reg.k3;
            default: prdata = '0;
        endcase
    end

    // stage chain: index 0 is the input side, index Stages the output register
    logic       st_valid [Stages+1];
    logic       st_ready [Stages+1];
    tea_stage_t st_data  [Stages+1];

    assign st_valid[0]      = blk_valid;
    assign blk_ready        = st_ready[0];
    assign st_data[0].op    = blk.op;
    assign st_data[0].a     = blk.half_a_in;
    assign st_data[0].b     = blk.half_b_in;
    assign st_data[0].last  = blk.last_in;

    for (genvar s = 0; s < Stages; s++)
    begin : g_stage
        tea_round #(
            .ROUNDS (ROUNDS),
            .STAGE  (s)
        ) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key_reg),
            .up_valid (st_valid[s]),
            .up_ready (st_ready[s]),
            .up       (st_data[s]),
            .dn_valid (st_valid[s+1]),
            .dn_ready (st_ready[s+1]),
            .dn       (st_data[s+1])
        );
    end

    assign st_ready[Stages] = res_ready;
    assign res_valid        = st_valid[Stages];
    assign res.half_a_out   = st_data[Stages].a;
    assign res.half_b_out   = st_data[Stages].b;
    assign res.last_out     = st_data[Stages].last;

endmodule
